### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cache set checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/sals_pkg.sv
// ----------------------------------------------------------------------------
// Cache set package
// Codes, field widths and the record that travels along the row of way cells.
// ----------------------------------------------------------------------------
package sals_pkg;

    // Width of the tag field on the input channel.
    localparam int TAG_W = 20;

    // Way index and rank fields in the scan record cover up to sixteen ways.
    localparam int IDX_W = 4;
    // Dirty count in the scan record covers up to sixteen dirty ways.
    localparam int CNT_W = 5;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Result outcomes.
    localparam logic [1:0] OUT_HIT     = 2'd0;
    localparam logic [1:0] OUT_MISS    = 2'd1;
    localparam logic [1:0] OUT_MISS_WB = 2'd2;

    // Record passed from one way cell to the next during the lookup scan.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_way;
        logic [IDX_W-1:0] hit_rank;
        logic             hit_dirty;
        logic             inv_found;
        logic [IDX_W-1:0] inv_way;
        logic [IDX_W-1:0] inv_rank;
        logic [IDX_W-1:0] lru_way;
        logic             lru_dirty;
        logic [CNT_W-1:0] dcount;
    } scan_t;

    // Update command broadcast to every way cell.
    typedef struct packed {
        logic             en;
        logic             fill;
        logic             wr;
        logic [IDX_W-1:0] way;
        logic [IDX_W-1:0] old_rank;
    } upd_cmd_t;

endpackage

### design/sals_cell.sv
// ----------------------------------------------------------------------------
// Way cell
// Holds one way's valid, dirty, tag and recency rank; folds its own state into
// the scan record handed to the next cell and applies broadcast updates.
// ----------------------------------------------------------------------------
module sals_cell #(
    parameter int WAYS = 4,
    parameter int TW   = 20,
    parameter int IDX  = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [TW-1:0]      tag,
    input  sals_pkg::upd_cmd_t cmd,
    input  sals_pkg::scan_t    scan_in,
    output sals_pkg::scan_t    scan_out
);

    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [WB-1:0] LAST_RANK = WB'(WAYS - 1);
    localparam logic [WB-1:0] OWN_RANK  = WB'(IDX);
    localparam logic [sals_pkg::IDX_W-1:0] MY_IDX = sals_pkg::IDX_W'(IDX);

    logic          valid_reg;
    logic          dirty_reg;
    logic [TW-1:0] tag_reg;
    logic [WB-1:0] rank_reg;

    logic [sals_pkg::IDX_W-1:0] my_rank;
    sals_pkg::scan_t            scan_next;
    sals_pkg::scan_t            scan_reg;

    assign my_rank = sals_pkg::IDX_W'(rank_reg);

    always_comb begin
        scan_next = scan_in;
        if (valid_reg && (tag_reg == tag)) begin
            scan_next.hit       = 1'b1;
            scan_next.hit_way   = MY_IDX;
            scan_next.hit_rank  = my_rank;
            scan_next.hit_dirty = dirty_reg;
        end
        if (!scan_in.inv_found && !valid_reg) begin
            scan_next.inv_found = 1'b1;
            scan_next.inv_way   = MY_IDX;
            scan_next.inv_rank  = my_rank;
        end
        if (rank_reg == LAST_RANK) begin
            scan_next.lru_way   = MY_IDX;
            scan_next.lru_dirty = dirty_reg;
        end
        scan_next.dcount = scan_in.dcount + sals_pkg::CNT_W'(dirty_reg);
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            rank_reg  <= OWN_RANK;
        end else if (cmd.en) begin
            if (cmd.way == MY_IDX) begin
                rank_reg <= '0;
                if (cmd.fill) begin
                    valid_reg <= 1'b1;
                    dirty_reg <= cmd.wr;
                end else begin
                    dirty_reg <= dirty_reg | cmd.wr;
                end
            end else if (my_rank < cmd.old_rank) begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.en && cmd.fill && (cmd.way == MY_IDX)) begin
            tag_reg <= tag;
        end
    end

endmodule

### design/set_assoc_lru_cache_set_unit.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache set
// One write-back cache set with true LRU replacement, built as a row of way
// cells that a lookup record walks through one cell per clock.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  access  | s_valid s_ready s_operation s_tag             | in
//  result  | m_valid m_ready m_outcome m_way m_dirty_count | out
//
// After acceptance the lookup record walks through the row of way cells in the
// scan state, and the update state follows, in which the result is registered;
// only then does the unit return to idle, so no new item is taken before the
// last result is registered. Synchronous active-low reset clears all valid and
// dirty bits and gives each way its own index as recency rank. While the
// previous result is not taken, the update waits and the cells hold.
//
// Each cell owns one way. During the scan the record collects the matching
// way, the lowest-numbered invalid way, the least recently used way and the
// dirty count before the access. The update cycle then broadcasts the chosen
// way and its old rank; every cell with a lower rank ages by one while the
// chosen way becomes most recently used.
//
module set_assoc_lru_cache_set_unit #(
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [19:0] s_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [1:0]  m_way,
    output logic [2:0]  m_dirty_count
);

    // Tag bits above TAG_BITS are ignored, so only the low bits are stored.
    localparam int TW = (TAG_BITS < sals_pkg::TAG_W) ? TAG_BITS : sals_pkg::TAG_W;
    localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [WB-1:0] LAST_STEP = WB'(WAYS - 1);
    localparam logic [sals_pkg::IDX_W-1:0] LRU_RANK = sals_pkg::IDX_W'(WAYS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t        state_reg;
    logic [WB-1:0] step_reg;
    logic          req_op_reg;
    logic [TW-1:0] req_tag_reg;

    logic       m_valid_reg;
    logic [1:0] m_outcome_reg;
    logic [1:0] m_way_reg;
    logic [2:0] m_dirty_count_reg;

    // Scan record between cells; entry 0 is the empty record fed to cell 0.
    sals_pkg::scan_t    chain [WAYS+1];
    sals_pkg::scan_t    res;
    sals_pkg::upd_cmd_t cmd;

    logic                       upd_fire;
    logic                       fill;
    logic [sals_pkg::IDX_W-1:0] sel_way;
    logic [sals_pkg::IDX_W-1:0] old_rank;
    logic                       old_dirty;
    logic                       new_dirty;
    logic [sals_pkg::CNT_W-1:0] dirty_next;
    logic [1:0]                 outcome_next;

    assign chain[0] = '0;

    for (genvar g = 0; g < WAYS; g++) begin : g_cell
        sals_cell #(
            .WAYS (WAYS),
            .TW   (TW),
            .IDX  (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .tag      (req_tag_reg),
            .cmd      (cmd),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1])
        );
    end

    // By the update state the last cell holds the complete record.
    assign res = chain[WAYS];

    always_comb begin
        fill = !res.hit;
        if (res.hit) begin
            sel_way   = res.hit_way;
            old_rank  = res.hit_rank;
            old_dirty = res.hit_dirty;
        end else if (res.inv_found) begin
            sel_way   = res.inv_way;
            old_rank  = res.inv_rank;
            old_dirty = 1'b0;
        end else begin
            sel_way   = res.lru_way;
            old_rank  = LRU_RANK;
            old_dirty = res.lru_dirty;
        end

        // A fill starts clean unless written; a hit keeps its dirty bit.
        new_dirty  = fill ? req_op_reg : (res.hit_dirty | req_op_reg);
        dirty_next = res.dcount - sals_pkg::CNT_W'(old_dirty)
                   + sals_pkg::CNT_W'(new_dirty);

        if (res.hit) begin
            outcome_next = sals_pkg::OUT_HIT;
        end else if (!res.inv_found && res.lru_dirty) begin
            outcome_next = sals_pkg::OUT_MISS_WB;
        end else begin
            outcome_next = sals_pkg::OUT_MISS;
        end
    end

    // The update is applied only when the output register can take the result.
    assign upd_fire = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd.en       = upd_fire;
        cmd.fill     = fill;
        cmd.wr       = (req_op_reg == sals_pkg::OP_WRITE);
        cmd.way      = sel_way;
        cmd.old_rank = old_rank;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && !upd_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_op_reg  <= s_operation;
                        req_tag_reg <= s_tag[TW-1:0];
                        step_reg    <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (step_reg == LAST_STEP) begin
                        state_reg <= ST_UPDATE;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_UPDATE: begin
                    if (upd_fire) begin
                        m_valid_reg       <= 1'b1;
                        m_outcome_reg     <= outcome_next;
                        m_way_reg         <= sel_way[1:0];
                        m_dirty_count_reg <= dirty_next[2:0];
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_outcome     = m_outcome_reg;
    assign m_way         = m_way_reg;
    assign m_dirty_count = m_dirty_count_reg;

endmodule

### design/sals_checker.sv
// ----------------------------------------------------------------------------
// Cache set port checker
// Watches the ports of the cache set and flags results that cannot occur.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sals_checker #(
    parameter int WAYS = 4
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_operation,
    input logic [19:0] s_tag,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_outcome,
    input logic [1:0]  m_way,
    input logic [2:0]  m_dirty_count
);

    // A stalled result holds its fields.
    `ASSERT_CLKD(a_result_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable({m_outcome, m_way, m_dirty_count})), "result changed while stalled")

    // Only one item is worked on at a time.
    `ASSERT_CLKD(a_one_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "accepted a second item while busy")

    // Every shown result carries a defined outcome code.
    `ASSERT_CLKD(a_outcome_code, aclk, aresetn, m_valid |-> ((m_outcome == sals_pkg::OUT_HIT) || (m_outcome == sals_pkg::OUT_MISS) || (m_outcome == sals_pkg::OUT_MISS_WB)), "undefined outcome code")

    // For up to seven ways, the dirty count never exceeds the number of ways.
    `ASSERT_CLKD(a_dirty_bound, aclk, aresetn, m_valid |-> ((WAYS > 7) || (32'(m_dirty_count) <= WAYS)), "dirty count above way count")

    // Right after reset no result is shown.
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result shown after reset")

endmodule

bind set_assoc_lru_cache_set_unit sals_checker #(.WAYS(WAYS)) u_sals_checker (.*);
